/* src/psec_pkg.sv */
package psec_pkg;

    localparam int MAX_RUN     = 64;
    localparam int RUN_AW      = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int RUN_CW      = $clog2(MAX_RUN + 1);
    localparam int MAX_RADIALS = 1024;
    localparam int RAD_AW      = $clog2(MAX_RADIALS);
    localparam int RAD_CW      = $clog2(MAX_RADIALS + 1);

    localparam int PH_W        = 16;
    localparam int GW_W        = 12;
    localparam int COH_W       = 10;
    localparam int DIST_W      = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_AW      = 3;

    localparam logic [GW_W-1:0] DEF_GW    = GW_W'(250);
    localparam int              FULL_TURN = 23040;

    // round(n/10) as ((n + 5) * RECIP_10) >> RECIP_SH
    localparam int RECIP_10 = 6554;
    localparam int RECIP_SH = 16;

    localparam logic [1:0] ACT_GATE = 2'd0;
    localparam logic [1:0] ACT_FIN  = 2'd1;
    localparam logic [1:0] ACT_CORR = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_USE_SUP  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_SUP_PH   = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_COH_THR  = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_RUN_DIST = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] CFG_MIN_RAD  = CFG_AW'(4);

    typedef enum logic [1:0] {
        ST_EST = 2'd0,
        ST_SUP = 2'd1,
        ST_FEW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_RD,
        RS_CMP,
        RS_PUT
    } t_run_st;

    typedef enum logic [1:0] {
        SS_IDLE,
        SS_SCAN,
        SS_DEC
    } t_sel_st;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_INS,
        TS_MUL,
        TS_CMP,
        TS_MWR,
        TS_FIN,
        TS_OUT
    } t_top_st;

    typedef struct packed {
        logic                   ins;
        logic signed [PH_W-1:0] value;
        logic [RUN_AW-1:0]      len;
        logic [RUN_AW-1:0]      idx;
    } t_run_cmd;

    typedef struct packed {
        logic                   done;
        logic signed [PH_W-1:0] data;
    } t_run_rsp;

    typedef struct packed {
        logic                   wr;
        logic [RAD_AW-1:0]      addr;
        logic signed [PH_W-1:0] wdata;
        logic                   start;
        logic [RAD_CW-1:0]      count;
        logic [RAD_CW-1:0]      k;
    } t_sel_cmd;

    typedef struct packed {
        logic                   done;
        logic signed [PH_W-1:0] value;
    } t_sel_rsp;

endpackage

/* src/psec_run.sv */
module psec_run (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psec_pkg::t_run_cmd i_cmd,
    output psec_pkg::t_run_rsp o_rsp
);

    logic signed [psec_pkg::PH_W-1:0] r_mem [psec_pkg::MAX_RUN];

    psec_pkg::t_run_st                r_state, n_state;
    logic [psec_pkg::RUN_AW-1:0]      r_j, n_j;
    logic signed [psec_pkg::PH_W-1:0] r_val, n_val;
    logic signed [psec_pkg::PH_W-1:0] r_rdata;
    logic                             r_done, n_done;

    logic                             wr_en;
    logic [psec_pkg::RUN_AW-1:0]      wr_addr, rd_addr;
    logic signed [psec_pkg::PH_W-1:0] wr_data;

    // insertion keeps the run sorted ascending
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_val   = r_val;
        n_done  = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = r_val;
        rd_addr = i_cmd.idx;
        unique case (r_state)
            psec_pkg::RS_IDLE: begin
                if (i_cmd.ins) begin
                    n_val   = i_cmd.value;
                    n_j     = i_cmd.len;
                    n_state = (i_cmd.len == '0) ? psec_pkg::RS_PUT : psec_pkg::RS_RD;
                end
            end
            psec_pkg::RS_RD: begin
                rd_addr = r_j - 1'b1;
                n_state = psec_pkg::RS_CMP;
            end
            psec_pkg::RS_CMP: begin
                wr_en = 1'b1;
                if (r_rdata > r_val) begin
                    wr_data = r_rdata;
                    n_j     = r_j - 1'b1;
                    n_state = (r_j == psec_pkg::RUN_AW'(1)) ? psec_pkg::RS_PUT : psec_pkg::RS_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = psec_pkg::RS_IDLE;
                end
            end
            psec_pkg::RS_PUT: begin
                wr_en   = 1'b1;
                n_done  = 1'b1;
                n_state = psec_pkg::RS_IDLE;
            end
            default: n_state = psec_pkg::RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psec_pkg::RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_j   <= n_j;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_rsp.done = r_done;
    assign o_rsp.data = r_rdata;

endmodule

/* src/psec_sel.sv */
module psec_sel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psec_pkg::t_sel_cmd i_cmd,
    output psec_pkg::t_sel_rsp o_rsp
);

    logic signed [psec_pkg::PH_W-1:0] r_mem [psec_pkg::MAX_RADIALS];

    psec_pkg::t_sel_st                r_state, n_state;
    logic [3:0]                       r_bit, n_bit;
    logic [psec_pkg::PH_W-1:0]        r_prefix, n_prefix;
    logic [psec_pkg::RAD_CW-1:0]      r_k, n_k;
    logic [psec_pkg::RAD_CW-1:0]      r_addr, n_addr;
    logic [psec_pkg::RAD_CW-1:0]      r_c0, n_c0;
    logic [psec_pkg::RAD_CW-1:0]      r_count, n_count;
    logic                             r_pend, n_pend;
    logic                             r_done, n_done;
    logic signed [psec_pkg::PH_W-1:0] r_value, n_value;
    logic signed [psec_pkg::PH_W-1:0] r_rdata;

    logic [psec_pkg::PH_W-1:0]        u, mask_hi;
    logic                             hit, rd_en;

    // bitwise radix select, offset binary so unsigned order matches signed
    assign u       = r_rdata ^ 16'h8000;
    assign mask_hi = 16'(17'h1FFFF << ({1'b0, r_bit} + 5'd1));
    assign hit     = (((u ^ r_prefix) & mask_hi) == '0) && !u[r_bit];
    assign rd_en   = (r_addr != r_count);

    always_comb begin
        n_state  = r_state;
        n_bit    = r_bit;
        n_prefix = r_prefix;
        n_k      = r_k;
        n_addr   = r_addr;
        n_c0     = r_c0;
        n_count  = r_count;
        n_pend   = 1'b0;
        n_done   = 1'b0;
        n_value  = r_value;
        unique case (r_state)
            psec_pkg::SS_IDLE: begin
                if (i_cmd.start) begin
                    n_count  = i_cmd.count;
                    n_k      = i_cmd.k;
                    n_bit    = 4'd15;
                    n_prefix = '0;
                    n_addr   = '0;
                    n_c0     = '0;
                    n_state  = psec_pkg::SS_SCAN;
                end
            end
            psec_pkg::SS_SCAN: begin
                if (rd_en) begin
                    n_addr = r_addr + 1'b1;
                end
                n_pend = rd_en;
                if (r_pend && hit) begin
                    n_c0 = r_c0 + 1'b1;
                end
                if (!rd_en && !r_pend) begin
                    n_state = psec_pkg::SS_DEC;
                end
            end
            psec_pkg::SS_DEC: begin
                if (r_k >= r_c0) begin
                    n_prefix[r_bit] = 1'b1;
                    n_k             = r_k - r_c0;
                end
                if (r_bit == 4'd0) begin
                    n_value = n_prefix ^ 16'h8000;
                    n_done  = 1'b1;
                    n_state = psec_pkg::SS_IDLE;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_addr  = '0;
                    n_c0    = '0;
                    n_state = psec_pkg::SS_SCAN;
                end
            end
            default: n_state = psec_pkg::SS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psec_pkg::SS_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_bit    <= n_bit;
        r_prefix <= n_prefix;
        r_k      <= n_k;
        r_addr   <= n_addr;
        r_c0     <= n_c0;
        r_count  <= n_count;
        r_value  <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[r_addr[psec_pkg::RAD_AW-1:0]];
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

/* src/radar_system_phase_estimate_correct.sv */
// Channel   Dir  Handshake              Payload
// s (item)  in   i_s_tvalid/o_s_tready  tdata gate fields, tuser action
// m (res)   out  o_m_tvalid/i_m_tready  tdata phases and count, tuser status
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_addr register index, i_cfg_data
//
// Correct gate and plain finish go straight to the output state. An analysis gate that is
// skipped or not qualifying ends in idle; else it is inserted into the sorted run while
// that is not full, the run test follows, and its median is stored when the run completes.
// Estimating finish runs the radix select, which walks the median memory once per bit.
// Synchronous active-low reset, no memory clearing. The block takes a transaction
// while a result waits.
module radar_system_phase_estimate_correct (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [0] radial_start, [16:1] phase_value, [17] phase_good, [27:18] coherence,
    // [28] coherence_good, [40:29] gate_width_m, rest zero
    input  logic [psec_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [1:0] action
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [15:0] corrected_phase, [31:16] system_phase, [42:32] radial_count, rest zero
    output logic [psec_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [1:0] status
    output logic [1:0]                          o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psec_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [15:0]                         i_cfg_data
);

    logic                              r_use_sup;
    logic signed [psec_pkg::PH_W-1:0]  r_sup_ph;
    logic [psec_pkg::COH_W-1:0]        r_coh_thr;
    logic [psec_pkg::DIST_W-1:0]       r_run_dist;
    logic [psec_pkg::RAD_CW-1:0]       r_min_rad;

    psec_pkg::t_top_st                 r_state, n_state;
    logic [psec_pkg::RUN_CW-1:0]       r_cnt, n_cnt;
    logic                              r_found, n_found;
    logic [psec_pkg::RAD_CW-1:0]       r_med_cnt, n_med_cnt;
    logic signed [psec_pkg::PH_W-1:0]  r_piu, n_piu;
    logic                              r_corr_en, n_corr_en;
    psec_pkg::t_status                 r_status, n_status;
    logic [psec_pkg::RAD_CW-1:0]       r_last_cnt, n_last_cnt;
    logic [psec_pkg::GW_W-1:0]         r_w, n_w;
    logic [20:0]                       r_prod, n_prod;
    logic [17:0]                       r_num, n_num;
    logic signed [psec_pkg::PH_W-1:0]  r_res, n_res;
    logic                              r_ovalid, n_ovalid;
    logic [psec_pkg::OUT_TDATA_W-1:0]  r_odata, n_odata;
    logic [1:0]                        r_ouser, n_ouser;

    psec_pkg::t_run_cmd                run_cmd;
    psec_pkg::t_run_rsp                run_rsp;
    psec_pkg::t_sel_cmd                sel_cmd;
    psec_pkg::t_sel_rsp                sel_rsp;

    logic                              in_rstart, in_pgood, in_cgood, s_acc, qual, found_e;
    logic signed [psec_pkg::PH_W-1:0]  in_phase, corr;
    logic [psec_pkg::COH_W-1:0]        in_coh;
    logic [psec_pkg::GW_W-1:0]         in_gw;
    logic [psec_pkg::RUN_CW-1:0]       cnt_e;
    logic signed [17:0]                diff, wrapped;
    logic [psec_pkg::RAD_CW:0]         k_sum;
    logic [psec_pkg::RAD_CW+16:0]      k_prod;
    logic [psec_pkg::RAD_CW-1:0]       k_raw, k_idx;

    assign in_rstart = i_s_tdata[0];
    assign in_phase  = i_s_tdata[16:1];
    assign in_pgood  = i_s_tdata[17];
    assign in_coh    = i_s_tdata[27:18];
    assign in_cgood  = i_s_tdata[28];
    assign in_gw     = i_s_tdata[40:29];

    assign o_s_tready  = (r_state == psec_pkg::TS_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;

    assign cnt_e   = in_rstart ? '0 : r_cnt;
    assign found_e = in_rstart ? 1'b0 : r_found;
    assign qual    = in_pgood && in_cgood && (in_coh > r_coh_thr);

    // wrap into one full turn
    localparam logic signed [17:0] FT  = 18'(psec_pkg::FULL_TURN);
    localparam logic signed [17:0] FT2 = 18'(2 * psec_pkg::FULL_TURN);
    localparam logic signed [17:0] FT3 = 18'(3 * psec_pkg::FULL_TURN);
    assign diff = 18'(in_phase) - 18'(r_piu);
    always_comb begin
        if (diff >= FT2)          wrapped = diff - FT2;
        else if (diff >= FT)      wrapped = diff - FT;
        else if (diff >= 0)       wrapped = diff;
        else if (diff >= -FT)     wrapped = diff + FT;
        else if (diff >= -FT2)    wrapped = diff + FT2;
        else                      wrapped = diff + FT3;
    end
    assign corr = (r_corr_en && in_pgood) ? wrapped[psec_pkg::PH_W-1:0] : in_phase;

    assign k_sum  = {1'b0, r_med_cnt} + (psec_pkg::RAD_CW + 1)'(5);
    assign k_prod = (psec_pkg::RAD_CW + 17)'(k_sum) * (psec_pkg::RAD_CW + 17)'(psec_pkg::RECIP_10);
    assign k_raw  = k_prod[psec_pkg::RECIP_SH +: psec_pkg::RAD_CW];
    assign k_idx  = (k_raw >= r_med_cnt) ? r_med_cnt - 1'b1 : k_raw;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_med_cnt  = r_med_cnt;
        n_piu      = r_piu;
        n_corr_en  = r_corr_en;
        n_status   = r_status;
        n_last_cnt = r_last_cnt;
        n_w        = r_w;
        n_prod     = r_prod;
        n_num      = r_num;
        n_res      = r_res;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_odata    = r_odata;
        n_ouser    = r_ouser;
        run_cmd    = '0;
        sel_cmd    = '0;
        unique case (r_state)
            psec_pkg::TS_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        psec_pkg::ACT_GATE: begin
                            n_found = found_e;
                            n_cnt   = cnt_e;
                            if (!found_e) begin
                                if (!qual) begin
                                    n_cnt = '0;
                                end else begin
                                    n_w = (in_gw == '0) ? psec_pkg::DEF_GW : in_gw;
                                    if (cnt_e < psec_pkg::RUN_CW'(psec_pkg::MAX_RUN)) begin
                                        run_cmd.ins   = 1'b1;
                                        run_cmd.value = in_phase;
                                        run_cmd.len   = cnt_e[psec_pkg::RUN_AW-1:0];
                                        n_cnt         = cnt_e + 1'b1;
                                        n_state       = psec_pkg::TS_INS;
                                    end else begin
                                        n_state = psec_pkg::TS_MUL;
                                    end
                                end
                            end
                        end
                        psec_pkg::ACT_FIN: begin
                            n_last_cnt = r_med_cnt;
                            n_res      = '0;
                            if (r_use_sup) begin
                                n_piu     = r_sup_ph;
                                n_corr_en = 1'b1;
                                n_status  = psec_pkg::ST_SUP;
                                n_state   = psec_pkg::TS_OUT;
                            end else if (r_med_cnt == '0 || r_med_cnt < r_min_rad) begin
                                n_piu     = '0;
                                n_corr_en = 1'b0;
                                n_status  = psec_pkg::ST_FEW;
                                n_med_cnt = '0;
                                n_cnt     = '0;
                                n_found   = 1'b0;
                                n_state   = psec_pkg::TS_OUT;
                            end else begin
                                sel_cmd.start = 1'b1;
                                sel_cmd.count = r_med_cnt;
                                sel_cmd.k     = k_idx;
                                n_state       = psec_pkg::TS_FIN;
                            end
                        end
                        psec_pkg::ACT_CORR: begin
                            n_res   = corr;
                            n_state = psec_pkg::TS_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            psec_pkg::TS_INS: begin
                if (run_rsp.done) begin
                    n_state = psec_pkg::TS_MUL;
                end
            end
            psec_pkg::TS_MUL: begin
                // run_count >= round(d / w)  <=>  2d + w < (run_count + 1) * 2w
                n_prod  = 21'(r_cnt + 1'b1) * 21'({r_w, 1'b0});
                n_num   = {1'b0, r_run_dist, 1'b0} + 18'(r_w);
                n_state = psec_pkg::TS_CMP;
            end
            psec_pkg::TS_CMP: begin
                if (r_cnt == psec_pkg::RUN_CW'(psec_pkg::MAX_RUN) || 21'(r_num) < r_prod) begin
                    n_found     = 1'b1;
                    run_cmd.idx = r_cnt[psec_pkg::RUN_CW-1:1];
                    n_state     = psec_pkg::TS_MWR;
                end else begin
                    n_state = psec_pkg::TS_IDLE;
                end
            end
            psec_pkg::TS_MWR: begin
                if (r_med_cnt < psec_pkg::RAD_CW'(psec_pkg::MAX_RADIALS)) begin
                    sel_cmd.wr    = 1'b1;
                    sel_cmd.addr  = r_med_cnt[psec_pkg::RAD_AW-1:0];
                    sel_cmd.wdata = run_rsp.data;
                    n_med_cnt     = r_med_cnt + 1'b1;
                end
                n_state = psec_pkg::TS_IDLE;
            end
            psec_pkg::TS_FIN: begin
                if (sel_rsp.done) begin
                    n_piu     = sel_rsp.value;
                    n_corr_en = 1'b1;
                    n_status  = psec_pkg::ST_EST;
                    n_med_cnt = '0;
                    n_cnt     = '0;
                    n_found   = 1'b0;
                    n_state   = psec_pkg::TS_OUT;
                end
            end
            psec_pkg::TS_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = psec_pkg::OUT_TDATA_W'({r_last_cnt, r_piu, r_res});
                    n_ouser  = r_status;
                    n_state  = psec_pkg::TS_IDLE;
                end
            end
            default: n_state = psec_pkg::TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psec_pkg::TS_IDLE;
            r_cnt      <= '0;
            r_found    <= 1'b0;
            r_med_cnt  <= '0;
            r_piu      <= '0;
            r_corr_en  <= 1'b0;
            r_status   <= psec_pkg::ST_FEW;
            r_last_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_found    <= n_found;
            r_med_cnt  <= n_med_cnt;
            r_piu      <= n_piu;
            r_corr_en  <= n_corr_en;
            r_status   <= n_status;
            r_last_cnt <= n_last_cnt;
            r_ovalid   <= n_ovalid;
        end
        r_w     <= n_w;
        r_prod  <= n_prod;
        r_num   <= n_num;
        r_res   <= n_res;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_sup  <= 1'b0;
            r_sup_ph   <= '0;
            r_coh_thr  <= psec_pkg::COH_W'(950);
            r_run_dist <= psec_pkg::DIST_W'(2750);
            r_min_rad  <= psec_pkg::RAD_CW'(5);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                psec_pkg::CFG_USE_SUP:  r_use_sup  <= i_cfg_data[0];
                psec_pkg::CFG_SUP_PH:   r_sup_ph   <= i_cfg_data;
                psec_pkg::CFG_COH_THR:  r_coh_thr  <= i_cfg_data[psec_pkg::COH_W-1:0];
                psec_pkg::CFG_RUN_DIST: r_run_dist <= i_cfg_data;
                psec_pkg::CFG_MIN_RAD:  r_min_rad  <= i_cfg_data[psec_pkg::RAD_CW-1:0];
                default: ;
            endcase
        end
    end

    psec_run u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (run_cmd),
        .o_rsp   (run_rsp)
    );

    psec_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sel_cmd),
        .o_rsp   (sel_rsp)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

/* src/psec_checker.sv */
module psec_sva (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [psec_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]                       o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == psec_pkg::ST_FEW |-> o_m_tdata[31:16] == '0)
        else $error("system phase not zero without estimate");

    a_est_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == psec_pkg::ST_EST |-> o_m_tdata[42:32] != '0)
        else $error("estimate reported with no radials");

endmodule

bind radar_system_phase_estimate_correct psec_sva u_psec_sva (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
